[sv/tpsc_pkg.sv]
`default_nettype none

package tpsc_pkg;

  // field and register widths
  localparam int SEL_W     = 2;
  localparam int GAIN_W    = 16;
  localparam int TS_W      = 16;
  localparam int EL_W      = 20;
  localparam int OUT_W     = 14;
  localparam int FRAC_W    = 12;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;

  // elapsed time path: t = el * ts, numerator = t * 2^8 + half, dt = numerator / 1e6
  localparam int T_W   = EL_W + TS_W;
  localparam int NUM_W = T_W + 8;
  localparam int DT_W  = 25;
  localparam int REM_W = 20;
  localparam int CNT_W = 5;

  // clamped sum before rounding, in Q14.12
  localparam int NV_W = 26;

  localparam int US_PER_S    = 1000000;
  localparam int HALF_US     = 500000;
  localparam int STEER_LIMIT = 6430;
  localparam int STEER_GUARD = 6431;

  localparam logic [SEL_W-1:0] SEL_NEAR = 2'd0;
  localparam logic [SEL_W-1:0] SEL_FAR  = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_FAR_GAIN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_GAIN  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INT_GAIN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIME_SCALE = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd71;
  localparam logic [TS_W-1:0]   TIME_SCALE_RST = 16'd256;

endpackage

`default_nettype wire

[sv/two_point_steering_controller.sv]
`default_nettype none

// channel   | handshake                        | payload
// ----------+----------------------------------+---------------------------------------------
// input     | in_valid / in_ready              | in_point_select, in_aim_angle, in_elapsed_us
// result    | out_valid / out_ready            | out_steering_angle
// config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// out_valid rises after an input beat has passed through one bit-serial shift-add unit
// (a 16-bit elapsed-time pass, three signed 16-bit gain passes, a 25-bit integral pass)
// and a 25-step restoring divide by one million; in_ready stays low until the result is
// moved to the output register, so only one input is in flight at a time.
// rst_n is synchronous; it clears the held angles and loads the register defaults.
// a held result never blocks input; a second result waits in the final step until taken.

module two_point_steering_controller #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tpsc_pkg::SEL_W-1:0]          in_point_select,
  input  logic signed [ANGLE_WIDTH-1:0]       in_aim_angle,
  input  logic [tpsc_pkg::EL_W-1:0]           in_elapsed_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpsc_pkg::OUT_W-1:0]   out_steering_angle,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpsc_pkg::PADDR_W-1:0]        paddr,
  input  logic [tpsc_pkg::PDATA_W-1:0]        pwdata,
  output logic [tpsc_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  import tpsc_pkg::*;

  // angle change, running sum (Q.12) and product widths
  localparam int DW = ANGLE_WIDTH + 1;
  localparam int SW = ANGLE_WIDTH + 26;
  localparam int PW = ANGLE_WIDTH + 41;

  localparam logic signed [SW-1:0]    LIM_S   = SW'(STEER_GUARD * (1 << FRAC_W));
  localparam logic signed [SW-1:0]    NLIM_S  = -LIM_S;
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(STEER_LIMIT);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX;

  typedef enum logic [3:0] {
    S_IDLE, S_TMUL, S_DIVLD, S_DIV, S_FAR, S_NEAR, S_IMUL, S_ABS, S_IDT, S_INTEG, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0] far_gain_r, far_gain_nxt;
  logic [GAIN_W-1:0] near_gain_r, near_gain_nxt;
  logic [GAIN_W-1:0] int_gain_r, int_gain_nxt;
  logic [TS_W-1:0]   time_scale_r, time_scale_nxt;

  logic signed [ANGLE_WIDTH-1:0] near_now_r, near_now_nxt;
  logic signed [ANGLE_WIDTH-1:0] near_prev_r, near_prev_nxt;
  logic signed [ANGLE_WIDTH-1:0] far_now_r, far_now_nxt;
  logic signed [ANGLE_WIDTH-1:0] far_prev_r, far_prev_nxt;
  logic signed [OUT_W-1:0]       steer_now_r, steer_now_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [PW-1:0]         mc_r, mc_nxt;
  logic [DT_W-1:0]       mp_r, mp_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [DT_W-1:0]       lo_r, lo_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DT_W-1:0]       dt_r, dt_nxt;

  logic                    wr_en;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    is_sum;
  logic                    sgn_last;
  logic                    sub;
  logic [PW-1:0]           addend;
  logic [PW-1:0]           tgt;
  logic [PW-1:0]           acc_res;
  logic [REM_W:0]          trial;
  logic                    ge;
  logic [NUM_W-1:0]        num;
  logic signed [DW-1:0]    far_diff;
  logic signed [DW-1:0]    near_diff;
  logic signed [NV_W-1:0]  nvc;
  logic signed [NV_W-1:0]  rsum;
  logic signed [OUT_W-1:0] rnd;
  logic signed [OUT_W-1:0] res;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_steering_angle = out_data_r;
  assign pready             = 1'b1;
  assign reg_idx            = paddr[PADDR_W-1:2];
  assign wr_en              = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_FAR_GAIN:   prdata = PDATA_W'(far_gain_r);
      REG_NEAR_GAIN:  prdata = PDATA_W'(near_gain_r);
      REG_INT_GAIN:   prdata = PDATA_W'(int_gain_r);
      REG_TIME_SCALE: prdata = PDATA_W'(time_scale_r);
    endcase
  end

  // shared shift-add step; the gain's top bit carries negative weight
  assign is_sum   = (state_r == S_FAR) || (state_r == S_NEAR);
  assign sgn_last = (is_sum || (state_r == S_IMUL)) && (cnt_r == CNT_W'(GAIN_W - 1));
  assign sub      = is_sum ^ sgn_last;
  assign addend   = mp_r[0] ? mc_r : '0;
  assign tgt      = is_sum ? PW'(sum_r) : prod_r;
  assign acc_res  = tgt + (addend ^ {PW{sub}}) + PW'(sub);

  // restoring divide by one million, one quotient bit a cycle
  assign trial = {rem_r, lo_r[DT_W-1]};
  assign ge    = (trial >= (REM_W + 1)'(US_PER_S));
  assign num   = {prod_r[T_W-1:0], {(NUM_W - T_W){1'b0}}} + NUM_W'(HALF_US);

  assign far_diff  = DW'(far_now_r) - DW'(far_prev_r);
  assign near_diff = DW'(near_now_r) - DW'(near_prev_r);

  // clamp, round half up from Q.12 to an integer, clamp again
  always_comb begin
    if (sum_r > LIM_S) begin
      nvc = NV_W'(LIM_S);
    end else if (sum_r < NLIM_S) begin
      nvc = NV_W'(NLIM_S);
    end else begin
      nvc = sum_r[NV_W-1:0];
    end
    rsum = nvc + NV_W'(1 << (FRAC_W - 1));
    rnd  = rsum[NV_W-1:FRAC_W];
    if (rnd > OUT_MAX) begin
      res = OUT_MAX;
    end else if (rnd < OUT_MIN) begin
      res = OUT_MIN;
    end else begin
      res = rnd;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    far_gain_nxt   = far_gain_r;
    near_gain_nxt  = near_gain_r;
    int_gain_nxt   = int_gain_r;
    time_scale_nxt = time_scale_r;
    near_now_nxt   = near_now_r;
    near_prev_nxt  = near_prev_r;
    far_now_nxt    = far_now_r;
    far_prev_nxt   = far_prev_r;
    steer_now_nxt  = steer_now_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mc_nxt         = mc_r;
    mp_nxt         = mp_r;
    prod_nxt       = prod_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    lo_nxt         = lo_r;
    rem_nxt        = rem_r;
    dt_nxt         = dt_r;

    if (wr_en) begin
      unique case (reg_idx)
        REG_FAR_GAIN:   far_gain_nxt   = pwdata[GAIN_W-1:0];
        REG_NEAR_GAIN:  near_gain_nxt  = pwdata[GAIN_W-1:0];
        REG_INT_GAIN:   int_gain_nxt   = pwdata[GAIN_W-1:0];
        REG_TIME_SCALE: time_scale_nxt = pwdata[TS_W-1:0];
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_point_select == SEL_NEAR) begin
            near_now_nxt = in_aim_angle;
          end else if (in_point_select == SEL_FAR) begin
            far_now_nxt = in_aim_angle;
          end
          mc_nxt    = PW'(in_elapsed_us);
          mp_nxt    = DT_W'(time_scale_r);
          prod_nxt  = '0;
          sum_nxt   = SW'($signed({steer_now_r, {FRAC_W{1'b0}}}));
          cnt_nxt   = '0;
          state_nxt = S_TMUL;
        end
      end
      S_TMUL, S_IMUL, S_IDT: begin
        prod_nxt = acc_res;
        mc_nxt   = mc_r << 1;
        mp_nxt   = mp_r >> 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (state_r == S_TMUL && cnt_r == CNT_W'(TS_W - 1)) begin
          state_nxt = S_DIVLD;
        end else if (state_r == S_IMUL && cnt_r == CNT_W'(GAIN_W - 1)) begin
          state_nxt = S_ABS;
        end else if (state_r == S_IDT && cnt_r == CNT_W'(DT_W - 1)) begin
          state_nxt = S_INTEG;
        end
      end
      S_DIVLD: begin
        rem_nxt   = REM_W'(num[NUM_W-1:DT_W]);
        lo_nxt    = num[DT_W-1:0];
        mc_nxt    = PW'(far_diff);
        mp_nxt    = DT_W'(far_gain_r);
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? REM_W'(trial - (REM_W + 1)'(US_PER_S)) : trial[REM_W-1:0];
        dt_nxt  = {dt_r[DT_W-2:0], ge};
        lo_nxt  = lo_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DT_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FAR;
        end
      end
      S_FAR, S_NEAR: begin
        sum_nxt = SW'(acc_res);
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          cnt_nxt = '0;
          if (state_r == S_FAR) begin
            mc_nxt    = PW'(near_diff);
            mp_nxt    = DT_W'(near_gain_r);
            state_nxt = S_NEAR;
          end else begin
            mc_nxt    = PW'(near_now_r);
            mp_nxt    = DT_W'(int_gain_r);
            prod_nxt  = '0;
            state_nxt = S_IMUL;
          end
        end
      end
      S_ABS: begin
        neg_nxt   = prod_r[PW-1];
        mc_nxt    = prod_r[PW-1] ? (~prod_r + 1'b1) : prod_r;
        mp_nxt    = dt_r;
        prod_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_IDT;
      end
      S_INTEG: begin
        // integral term truncated toward zero, sign restored here
        if (neg_r) begin
          sum_nxt = sum_r + SW'(prod_r[PW-1:16]);
        end else begin
          sum_nxt = sum_r - SW'(prod_r[PW-1:16]);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          steer_now_nxt = res;
          near_prev_nxt = near_now_r;
          far_prev_nxt  = far_now_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mc_r       <= mc_nxt;
    mp_r       <= mp_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    lo_r       <= lo_nxt;
    rem_r      <= rem_nxt;
    dt_r       <= dt_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      far_gain_r   <= GAIN_RST;
      near_gain_r  <= GAIN_RST;
      int_gain_r   <= GAIN_RST;
      time_scale_r <= TIME_SCALE_RST;
      near_now_r   <= '0;
      near_prev_r  <= '0;
      far_now_r    <= '0;
      far_prev_r   <= '0;
      steer_now_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      far_gain_r   <= far_gain_nxt;
      near_gain_r  <= near_gain_nxt;
      int_gain_r   <= int_gain_nxt;
      time_scale_r <= time_scale_nxt;
      near_now_r   <= near_now_nxt;
      near_prev_r  <= near_prev_nxt;
      far_now_r    <= far_now_nxt;
      far_prev_r   <= far_prev_nxt;
      steer_now_r  <= steer_now_nxt;
    end
  end

endmodule

`default_nettype wire

[dv/two_point_steering_controller_test.sv]
`timescale 1ns / 100ps

module two_point_steering_controller_test;
  import tpsc_pkg::*;

  localparam int ANG_W      = 16;
  localparam int N_PHASES   = 9;
  localparam int RAND_ITEMS = 215;
  localparam int QUIET_MAX  = 4000;
  localparam int TAIL_WAIT  = 150;
  localparam int MAX_PRINTS = 30;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [SEL_W-1:0]        sel;
    logic signed [ANG_W-1:0] angle;
    logic [EL_W-1:0]         elapsed;
  } aim_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SEL_W-1:0]         in_point_select = '0;
  logic signed [ANG_W-1:0]  in_aim_angle = '0;
  logic [EL_W-1:0]          in_elapsed_us = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [OUT_W-1:0]  out_steering_angle;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  always #4 clk = ~clk;

  two_point_steering_controller #(.ANGLE_WIDTH(ANG_W)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_point_select    (in_point_select),
    .in_aim_angle       (in_aim_angle),
    .in_elapsed_us      (in_elapsed_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_steering_angle (out_steering_angle),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // controller copy: gains and held angles
  logic signed [GAIN_W-1:0] far_gain      = GAIN_RST;
  logic signed [GAIN_W-1:0] near_gain     = GAIN_RST;
  logic signed [GAIN_W-1:0] integral_gain = GAIN_RST;
  logic [TS_W-1:0]          time_scale    = TIME_SCALE_RST;
  logic signed [ANG_W-1:0]  near_now  = '0;
  logic signed [ANG_W-1:0]  near_prev = '0;
  logic signed [ANG_W-1:0]  far_now   = '0;
  logic signed [ANG_W-1:0]  far_prev  = '0;
  logic signed [15:0]       steer_now = '0;

  aim_report_t             pending[$];
  logic signed [OUT_W-1:0] steer_due[$];
  aim_report_t             cur_rpt;

  int  reports_open  = 0;
  int  reports_taken = 0;
  int  beats_seen    = 0;
  int  at_limit      = 0;
  int  errors        = 0;
  int  settings_run  = 0;
  int  quiet         = 0;
  bit  idle_on       = 1'b0;
  bit  loaded        = 1'b0;
  int  gap_left      = 0;
  int  burst_left    = 0;
  int  stall_left    = 0;
  int  run_left      = 0;
  logic rdy_next;
  logic signed [OUT_W-1:0] want;

  function automatic logic signed [OUT_W-1:0] steer_predict(input aim_report_t rpt);
    longint acc, prod, integ, nv, res, lim;
    u64_t   tprod, dt, mag;
    lim = longint'(STEER_GUARD) * 4096;
    if (rpt.sel == SEL_NEAR) near_now = rpt.angle;
    else if (rpt.sel == SEL_FAR) far_now = rpt.angle;
    acc = longint'(far_gain) * (longint'(far_now) - longint'(far_prev))
        + longint'(near_gain) * (longint'(near_now) - longint'(near_prev));
    // elapsed time to Q.16 seconds, rounded half up
    tprod = u64_t'(rpt.elapsed) * u64_t'(time_scale);
    dt = (tprod * 256 + u64_t'(HALF_US)) / u64_t'(US_PER_S);
    // integral term truncated toward zero
    prod = longint'(integral_gain) * longint'(near_now);
    mag = (prod < 0) ? u64_t'(-prod) : u64_t'(prod);
    mag = (mag >> 16) * dt + (((mag & 64'hFFFF) * dt) >> 16);
    integ = (prod < 0) ? -longint'(mag) : longint'(mag);
    nv = longint'(steer_now) * 4096 - acc - integ;
    if (nv > lim) nv = lim;
    if (nv < -lim) nv = -lim;
    res = ((nv + lim + 2048) >>> FRAC_W) - STEER_GUARD;
    if (res > STEER_LIMIT) res = STEER_LIMIT;
    if (res < -STEER_LIMIT) res = -STEER_LIMIT;
    near_prev = near_now;
    far_prev  = far_now;
    steer_now = res[15:0];
    return res[OUT_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 6) return $urandom_range(1, 20);
    return $urandom_range(21, 180);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 3);
    if (r < 9) return $urandom_range(4, 40);
    return $urandom_range(41, 200);
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    int v;
    if ($urandom_range(0, 3) == 0) v = $urandom;
    else v = int'($urandom_range(0, 1200)) - 600;
    return v[GAIN_W-1:0];
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    int v;
    if ($urandom_range(0, 3) == 0) v = $urandom;
    else v = $urandom_range(64, 1024);
    return v[TS_W-1:0];
  endfunction

  task automatic add_report(input logic [SEL_W-1:0] sel, input logic signed [ANG_W-1:0] ang,
                            input logic [EL_W-1:0] el);
    aim_report_t rpt;
    rpt.sel     = sel;
    rpt.angle   = ang;
    rpt.elapsed = el;
    pending.push_back(rpt);
    reports_open++;
  endtask

  task automatic add_random_report();
    int   r;
    int   v;
    logic [31:0] rnd;
    logic signed [ANG_W-1:0] ang;
    logic [EL_W-1:0] el;
    rnd = $urandom;
    r = $urandom_range(0, 7);
    if (r == 0) ang = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    else if (r < 3) begin
      v = int'($urandom_range(0, 1600)) - 800;
      ang = v[ANG_W-1:0];
    end else ang = rnd[ANG_W-1:0];
    rnd = $urandom;
    r = $urandom_range(0, 7);
    if (r == 0) el = '1;
    else if (r == 1) begin
      v = $urandom_range(0, 100);
      el = v[EL_W-1:0];
    end else if (r < 5) begin
      v = $urandom_range(10000, 120000);
      el = v[EL_W-1:0];
    end else el = rnd[EL_W-1:0];
    rnd = $urandom;
    add_report(rnd[SEL_W-1:0], ang, el);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FAR_GAIN:   far_gain      = val;
      REG_NEAR_GAIN:  near_gain     = val;
      REG_INT_GAIN:   integral_gain = val;
      REG_TIME_SCALE: time_scale    = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] fg, input logic [GAIN_W-1:0] ng,
                           input logic [GAIN_W-1:0] ig, input logic [TS_W-1:0] ts);
    cfg_write(REG_FAR_GAIN, fg);
    cfg_write(REG_NEAR_GAIN, ng);
    cfg_write(REG_INT_GAIN, ig);
    cfg_write(REG_TIME_SCALE, ts);
  endtask

  task automatic wait_drained();
    while (reports_open != 0 || steer_due.size() != 0) @(posedge clk);
  endtask

  // input driver: bursts from the pending queue, with gaps between them when idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      loaded = 1'b0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        steer_due.push_back(steer_predict(cur_rpt));
        reports_open--;
        reports_taken++;
        loaded = 1'b0;
      end
      if (!loaded) begin
        if (gap_left > 0) gap_left--;
        else if (pending.size() > 0) begin
          cur_rpt = pending.pop_front();
          in_point_select <= cur_rpt.sel;
          in_aim_angle    <= cur_rpt.angle;
          in_elapsed_us   <= cur_rpt.elapsed;
          loaded = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 8);
          burst_left--;
          if (burst_left == 0 && idle_on) gap_left = pick_gap();
        end
      end
      in_valid <= loaded;
    end
  end

  // result monitor with its own stall pattern when idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      run_left = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (steer_due.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: steering beat with nothing pending: expected none, got %0d",
                     $time, out_steering_angle);
        end else begin
          want = steer_due.pop_front();
          if (want == STEER_LIMIT || want == -STEER_LIMIT) at_limit++;
          if (out_steering_angle !== want) begin
            errors++;
            if (errors <= MAX_PRINTS)
              $display("%0t: steering angle mismatch: expected %0d, got %0d",
                       $time, want, out_steering_angle);
          end
        end
      end
      if (!idle_on) rdy_next = 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        rdy_next = 1'b0;
      end else begin
        rdy_next = 1'b1;
        if (run_left > 0) run_left--;
        else begin
          run_left = $urandom_range(1, 30);
          stall_left = pick_stall();
        end
      end
      out_ready <= rdy_next;
    end
  end

  // watchdog on beats of either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no beat for %0d cycles, %0d reports and %0d results outstanding",
                 $time, quiet, reports_open, steer_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_on = (ph % 3 != 1);
      case (ph)
        0: ;  // reset values
        1: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        2: set_gains(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        3: set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        8: set_gains(GAIN_RST, GAIN_RST, GAIN_RST, TIME_SCALE_RST);
        default: set_gains(rand_gain(), rand_gain(), rand_gain(), rand_ts());
      endcase
      settings_run++;
      case (ph)
        0: begin
          add_report(SEL_NEAR, 16'sh7FFF, 20'd0);
          add_report(SEL_FAR, 16'sh8000, 20'hFFFFF);
          add_report(2'd2, 16'sd12345, 20'd20000);
          add_report(2'd3, -16'sd1, 20'd50000);
          add_report(SEL_NEAR, 16'sh8000, 20'hFFFFF);
          add_report(SEL_FAR, 16'sh7FFF, 20'd0);
          add_report(SEL_NEAR, 16'sd0, 20'd100);
          add_report(SEL_FAR, 16'sd0, 20'hFFFFF);
          add_report(2'd2, 16'sh8000, 20'hFFFFF);
        end
        1: begin
          // large gains drive the sum well past the limit both ways
          add_report(SEL_NEAR, 16'sh7FFF, 20'hFFFFF);
          add_report(SEL_NEAR, 16'sh8000, 20'hFFFFF);
          add_report(SEL_FAR, 16'sh7FFF, 20'd0);
          add_report(SEL_FAR, 16'sh8000, 20'd0);
          add_report(2'd3, 16'sh7FFF, 20'hFFFFF);
        end
        2: begin
          add_report(SEL_NEAR, 16'sh7FFF, 20'hFFFFF);
          add_report(SEL_FAR, 16'sh8000, 20'hFFFFF);
          add_report(SEL_NEAR, 16'sh8000, 20'd1);
          add_report(2'd2, 16'sd0, 20'hFFFFF);
        end
        3: begin
          add_report(2'd3, 16'sh8000, 20'hFFFFF);
          add_report(SEL_NEAR, 16'sd1, 20'hFFFFF);
        end
        default: ;
      endcase
      repeat (RAND_ITEMS) add_random_report();
      wait_drained();
    end
    repeat (TAIL_WAIT) @(posedge clk);
    $display("%0d aim reports over %0d gain settings, %0d steering beats checked",
             reports_taken, settings_run, beats_seen);
    $display("%0d results sat on the steering limit, %0d mismatches", at_limit, errors);
    if (errors == 0 && steer_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tpsc_pkg.sv
sv/two_point_steering_controller.sv
dv/two_point_steering_controller_test.sv
